// File: rtl/mshtu_pkg.sv
// shared types and constants for the masked subnet hash table unit
// no dependencies
`default_nettype none

package mshtu_pkg;

  localparam int unsigned BucketCount   = 256;
  localparam int unsigned BucketW       = $clog2(BucketCount);
  localparam int unsigned EntryCapacity = 256;
  localparam int unsigned IdxW          = $clog2(EntryCapacity);
  localparam int unsigned LinkW         = $clog2(EntryCapacity + 1);

  localparam logic [1:0] AlgoFixed = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0]      address;
    logic [31:0]      netmask;
    logic             handler;
    logic [15:0]      port;
    logic [LinkW-1:0] next;
  } entry_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic               clr;
    logic [BucketW-1:0] addr;
    logic [LinkW-1:0]   wdata;
  } head_req_t;

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [IdxW-1:0] addr;
    entry_t          wdata;
  } entry_req_t;

endpackage

`default_nettype wire

// File: rtl/mshtu_if.sv
// valid/ready channel interfaces for the request and result items
// depends on mshtu_pkg
`default_nettype none

interface mshtu_in_if import mshtu_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] ip;
  logic [31:0] mask;
  logic [1:0]  algo;
  logic [15:0] fixed_port;

  modport source (output valid, action, ip, mask, algo, fixed_port, input ready);
  modport sink   (input valid, action, ip, mask, algo, fixed_port, output ready);
endinterface

interface mshtu_out_if import mshtu_pkg::*;;
  logic        valid;
  logic        ready;
  logic        found;
  logic        handler;
  logic [15:0] port_out;
  logic        table_full;

  modport source (output valid, found, handler, port_out, table_full, input ready);
  modport sink   (input valid, found, handler, port_out, table_full, output ready);
endinterface

`default_nettype wire

// File: rtl/mshtu_head_mem.sv
// bucket head memory with per-bucket valid bits, registered read
// depends on mshtu_pkg
`default_nettype none

module mshtu_head_mem import mshtu_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire head_req_t        req_i,
  output logic [LinkW-1:0]      link_o
);

  logic [LinkW-1:0]       mem [BucketCount];
  logic [BucketCount-1:0] vld_q;
  logic [LinkW-1:0]       rdata_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign link_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: rtl/mshtu_entry_mem.sv
// entry storage: address, mask, handler, port and chain link per entry
// depends on mshtu_pkg
`default_nettype none

module mshtu_entry_mem import mshtu_pkg::*; (
  input  wire logic       clk_i,
  input  wire entry_req_t req_i,
  output entry_t          rdata_o
);

  entry_t mem [EntryCapacity];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/mshtu_ctrl.sv
// sequencer: insert, chain walk for lookup, clear, and the result register
// depends on mshtu_pkg and mshtu_if
`default_nettype none

module mshtu_ctrl import mshtu_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  mshtu_in_if.sink          in_i,
  mshtu_out_if.source       out_o,
  output head_req_t         head_req_o,
  input  wire logic [LinkW-1:0] head_link_i,
  output entry_req_t        entry_req_o,
  input  wire entry_t       entry_i
);

  state_e           state_q, state_d;
  logic [1:0]       act_q, act_d;
  logic [31:0]      ip_q, ip_d;
  logic [31:0]      mask_q, mask_d;
  logic             hsel_q, hsel_d;
  logic [15:0]      port_q, port_d;
  logic [LinkW-1:0] used_q, used_d;
  logic             found_q, found_d;
  logic             hnd_q, hnd_d;
  logic [15:0]      pout_q, pout_d;
  logic             full_q, full_d;
  logic             ovld_q, ovld_d;
  logic             ofound_q, ofound_d;
  logic             ohnd_q, ohnd_d;
  logic [15:0]      opout_q, opout_d;
  logic             ofull_q, ofull_d;

  logic             in_acc;
  logic             is_full;
  logic             hit;
  logic             out_free;
  logic [LinkW-1:0] head_m1;
  logic [LinkW-1:0] next_m1;

  assign in_acc   = in_i.valid && (state_q == ST_IDLE);
  assign is_full  = (used_q >= LinkW'(EntryCapacity));
  assign hit      = ((ip_q & entry_i.netmask) == entry_i.address);
  assign out_free = !ovld_q || out_o.ready;
  assign head_m1  = head_link_i - 1'b1;
  assign next_m1  = entry_i.next - 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (in_i.action)
            ACT_LOOKUP: state_d = ST_HEAD;
            ACT_INSERT: state_d = is_full ? ST_DONE : ST_HEAD;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_HEAD: begin
        if (act_q == ACT_INSERT || head_link_i == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit || entry_i.next == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    act_d    = act_q;
    ip_d     = ip_q;
    mask_d   = mask_q;
    hsel_d   = hsel_q;
    port_d   = port_q;
    used_d   = used_q;
    found_d  = found_q;
    hnd_d    = hnd_q;
    pout_d   = pout_q;
    full_d   = full_q;
    ovld_d   = ovld_q && !out_o.ready;
    ofound_d = ofound_q;
    ohnd_d   = ohnd_q;
    opout_d  = opout_q;
    ofull_d  = ofull_q;

    head_req_o = '0;
    entry_req_o = '0;
    head_req_o.addr = ip_q[BucketW-1:0];

    case (state_q)
      ST_IDLE: begin
        head_req_o.addr = in_i.ip[BucketW-1:0];
        if (in_acc) begin
          act_d   = in_i.action;
          ip_d    = in_i.ip;
          mask_d  = in_i.mask;
          hsel_d  = (in_i.algo == AlgoFixed);
          port_d  = in_i.fixed_port;
          found_d = 1'b0;
          hnd_d   = 1'b0;
          pout_d  = '0;
          full_d  = 1'b0;
          case (in_i.action)
            ACT_LOOKUP: head_req_o.rd_en = 1'b1;
            ACT_INSERT: begin
              if (is_full) begin
                full_d = 1'b1;
              end else begin
                head_req_o.rd_en = 1'b1;
              end
            end
            ACT_CLEAR: begin
              head_req_o.clr = 1'b1;
              used_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_HEAD: begin
        if (act_q == ACT_INSERT) begin
          entry_req_o.wr_en         = 1'b1;
          entry_req_o.addr          = used_q[IdxW-1:0];
          entry_req_o.wdata.address = ip_q;
          entry_req_o.wdata.netmask = mask_q;
          entry_req_o.wdata.handler = hsel_q;
          entry_req_o.wdata.port    = port_q;
          entry_req_o.wdata.next    = head_link_i;
          head_req_o.wr_en          = 1'b1;
          head_req_o.wdata          = used_q + 1'b1;
          used_d                    = used_q + 1'b1;
        end else if (head_link_i != '0) begin
          entry_req_o.rd_en = 1'b1;
          entry_req_o.addr  = head_m1[IdxW-1:0];
        end
      end
      ST_WALK: begin
        if (hit) begin
          found_d = 1'b1;
          hnd_d   = entry_i.handler;
          pout_d  = entry_i.port;
        end else if (entry_i.next != '0) begin
          entry_req_o.rd_en = 1'b1;
          entry_req_o.addr  = next_m1[IdxW-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ovld_d   = 1'b1;
          ofound_d = found_q;
          ohnd_d   = hnd_q;
          opout_d  = pout_q;
          ofull_d  = full_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    ip_q     <= ip_d;
    mask_q   <= mask_d;
    hsel_q   <= hsel_d;
    port_q   <= port_d;
    found_q  <= found_d;
    hnd_q    <= hnd_d;
    pout_q   <= pout_d;
    full_q   <= full_d;
    ofound_q <= ofound_d;
    ohnd_q   <= ohnd_d;
    opout_q  <= opout_d;
    ofull_q  <= ofull_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = ovld_q;
  assign out_o.found      = ofound_q;
  assign out_o.handler    = ohnd_q;
  assign out_o.port_out   = opout_q;
  assign out_o.table_full = ofull_q;

endmodule

`default_nettype wire

// File: rtl/masked_subnet_hash_table_unit.sv
// masked subnet hash table: 256 chained buckets keyed by ip[7:0], lookup walks newest first
// clear, an unused action code and an insert into a full table go straight to the result state;
// insert reads the bucket head, then writes the entry and the new head; lookup reads the bucket
// head and then the entry memory for each chain entry, until a hit or the end of the chain
// one item in flight at a time; the next item is taken once the result is in the output register
// reset empties all buckets (valid bits) and frees all entries; no clearing pass
// depends on mshtu_pkg, mshtu_if, mshtu_head_mem, mshtu_entry_mem, mshtu_ctrl
`default_nettype none

module masked_subnet_hash_table_unit import mshtu_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mshtu_in_if.sink    in_i,
  mshtu_out_if.source out_o
);

  head_req_t        head_req;
  logic [LinkW-1:0] head_link;
  entry_req_t       entry_req;
  entry_t           entry_rdata;

  mshtu_head_mem u_head_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (head_req),
    .link_o (head_link)
  );

  mshtu_entry_mem u_entry_mem (
    .clk_i   (clk_i),
    .req_i   (entry_req),
    .rdata_o (entry_rdata)
  );

  mshtu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .head_req_o  (head_req),
    .head_link_i (head_link),
    .entry_req_o (entry_req),
    .entry_i     (entry_rdata)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking bench for masked_subnet_hash_table_unit: directed and random
// lookups, inserts and clears, checked against an in-bench table predictor
// depends on mshtu_pkg, mshtu_if and the rtl of the unit
`timescale 1ns / 1ps

module tb import mshtu_pkg::*; ;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [1:0] AlgoLfp   = 2'd0;
  localparam logic [1:0] AlgoLra   = 2'd1;
  localparam logic [1:0] AlgoOther = 2'd3;

  localparam int unsigned ItemTarget = 1400;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 50;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ip;
    logic [31:0] mask;
    logic [1:0]  algo;
    logic [15:0] port;
  } request_t;

  typedef struct packed {
    logic        found;
    logic        handler;
    logic [15:0] port;
    logic        full;
  } verdict_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] mask;
  } subnet_t;

  class subnet_table_scoreboard;
    logic [LinkW-1:0] head_link [BucketCount];
    logic [31:0]      ent_addr [EntryCapacity];
    logic [31:0]      ent_mask [EntryCapacity];
    logic             ent_handler [EntryCapacity];
    logic [15:0]      ent_port [EntryCapacity];
    logic [LinkW-1:0] ent_next [EntryCapacity];
    int unsigned      used_entries;
    verdict_t         awaited [$];
    int unsigned      failures;

    function new();
      failures = 0;
      empty_buckets();
    endfunction

    function void empty_buckets();
      foreach (head_link[b]) head_link[b] = '0;
      used_entries = 0;
    endfunction

    function verdict_t classify(request_t r);
      verdict_t         v;
      logic [LinkW-1:0] link;
      int unsigned      steps;
      int unsigned      e;
      logic [7:0]       bucket;
      v = '0;
      bucket = r.ip[7:0];
      case (r.action)
        ACT_LOOKUP: begin
          link = head_link[bucket];
          steps = 0;
          while (link != 0 && !v.found && steps < EntryCapacity) begin
            e = link - 1;
            if ((r.ip & ent_mask[e]) == ent_addr[e]) begin
              v.found = 1'b1;
              v.handler = ent_handler[e];
              v.port = ent_port[e];
            end
            link = ent_next[e];
            steps++;
          end
        end
        ACT_INSERT: begin
          if (used_entries >= EntryCapacity) begin
            v.full = 1'b1;
          end else begin
            e = used_entries;
            ent_addr[e] = r.ip;
            ent_mask[e] = r.mask;
            ent_handler[e] = (r.algo == AlgoFixed);
            ent_port[e] = r.port;
            ent_next[e] = head_link[bucket];
            head_link[bucket] = LinkW'(e + 1);
            used_entries = e + 1;
          end
        end
        ACT_CLEAR: empty_buckets();
        default: ;
      endcase
      return v;
    endfunction

    function void note_request(request_t r);
      awaited.push_back(classify(r));
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (awaited.size() == 0) begin
        if (failures < 10)
          $display("%0t: unexpected result found=%0b handler=%0b port=%h full=%0b",
                   $realtime, got.found, got.handler, got.port, got.full);
        failures++;
      end else begin
        want = awaited.pop_front();
        if (got.found !== want.found || got.handler !== want.handler ||
            got.port !== want.port || got.full !== want.full) begin
          if (failures < 10) begin
            $display("%0t: mismatch exp found=%0b handler=%0b port=%h full=%0b", $realtime,
                     want.found, want.handler, want.port, want.full);
            $display("%0t: mismatch got found=%0b handler=%0b port=%h full=%0b", $realtime,
                     got.found, got.handler, got.port, got.full);
          end
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mshtu_in_if  req_bus ();
  mshtu_out_if res_bus ();

  masked_subnet_hash_table_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (res_bus)
  );

  subnet_table_scoreboard sb = new();

  bit          hold_request;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned burst_left;
  subnet_t     known_nets [$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // monitor: results first, then the new item
  always @(posedge clk_i) begin
    verdict_t seen;
    request_t taken;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        seen.found = res_bus.found;
        seen.handler = res_bus.handler;
        seen.port = res_bus.port_out;
        seen.full = res_bus.table_full;
        sb.check_result(seen);
      end
      if (req_bus.valid && req_bus.ready) begin
        taken.action = req_bus.action;
        taken.ip = req_bus.ip;
        taken.mask = req_bus.mask;
        taken.algo = req_bus.algo;
        taken.port = req_bus.fixed_port;
        sb.note_request(taken);
      end
      if ((res_bus.valid && res_bus.ready) || (req_bus.valid && req_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // result side stall pattern
  initial begin
    int unsigned rx_mode;
    int unsigned rx_left;
    res_bus.ready = 1'b0;
    rx_mode = 0;
    rx_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_mode)
          0:       res_bus.ready <= 1'b1;
          1:       res_bus.ready <= 1'($urandom_range(0, 1));
          default: res_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(input logic [1:0] act, input logic [31:0] ip, input logic [31:0] mask,
                      input logic [1:0] algo, input logic [15:0] port);
    req_bus.valid <= 1'b1;
    req_bus.action <= act;
    req_bus.ip <= ip;
    req_bus.mask <= mask;
    req_bus.algo <= algo;
    req_bus.fixed_port <= port;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    send(2'($urandom_range(0, 3)), $urandom(), $urandom(), 2'($urandom_range(0, 3)),
         16'($urandom()));
  endtask

  task automatic send_subnet(input logic [7:0] bucket);
    logic [23:0] upper;
    logic [31:0] rnd;
    int unsigned plen;
    subnet_t     net;
    plen = $urandom_range(0, 24);
    upper = (plen == 0) ? 24'h0 : ~24'h0 << (24 - plen);
    rnd = $urandom();
    net.mask = {upper, 8'hff};
    net.addr = {rnd[31:8] & upper, bucket};
    known_nets.push_back(net);
    if (known_nets.size() > 64) void'(known_nets.pop_front());
    send(ACT_INSERT, net.addr, net.mask, 2'($urandom_range(0, 3)), 16'($urandom()));
  endtask

  task automatic send_known_lookup();
    subnet_t net;
    net = known_nets[$urandom_range(0, known_nets.size() - 1)];
    send(ACT_LOOKUP, net.addr | ($urandom() & ~net.mask), $urandom(),
         2'($urandom_range(0, 3)), 16'($urandom()));
  endtask

  task automatic subnet_phase(input int unsigned count, input bit fill);
    logic [7:0]  pool [4];
    int unsigned pool_size;
    int unsigned pick;
    int unsigned inserts;
    pool_size = $urandom_range(1, 4);
    foreach (pool[i]) pool[i] = 8'($urandom());
    if (fill) begin
      send(ACT_CLEAR, $urandom(), $urandom(), 2'($urandom_range(0, 3)), 16'($urandom()));
      inserts = 0;
      while (inserts < count) begin
        if ($urandom_range(0, 3) == 0 && known_nets.size() != 0) begin
          send_known_lookup();
        end else begin
          send_subnet(pool[$urandom_range(0, pool_size - 1)]);
          inserts++;
        end
      end
    end else begin
      repeat (count) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          send_subnet(pool[$urandom_range(0, pool_size - 1)]);
        else if (pick < 85 && known_nets.size() != 0)
          send_known_lookup();
        else if (pick < 92)
          send(ACT_LOOKUP, {24'($urandom()), pool[$urandom_range(0, pool_size - 1)]},
               $urandom(), 2'($urandom_range(0, 3)), 16'($urandom()));
        else if (pick < 96)
          send_noise();
        else
          send(ACT_CLEAR, $urandom(), $urandom(), 2'($urandom_range(0, 3)), 16'($urandom()));
      end
    end
  endtask

  initial begin
    int unsigned phase;
    rst_ni = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    burst_left = 0;
    req_bus.valid = 1'b0;
    req_bus.action = ACT_LOOKUP;
    req_bus.ip = '0;
    req_bus.mask = '0;
    req_bus.algo = AlgoLfp;
    req_bus.fixed_port = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, extremes, every handler code, chain order, clear
    send(ACT_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, AlgoOther, 16'hffff);
    send(ACT_INSERT, 32'h0000_0000, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff, AlgoFixed, 16'hffff);
    send(ACT_INSERT, 32'hc0a8_0100, 32'hffff_ff00, AlgoLra, 16'h1234);
    send(ACT_INSERT, 32'h0000_0080, 32'h0000_00ff, AlgoOther, 16'h8000);
    send(ACT_LOOKUP, 32'hc0a8_0100, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_LOOKUP, 32'h0000_0000, 32'hffff_ffff, AlgoFixed, 16'hffff);
    send(ACT_LOOKUP, 32'hffff_ffff, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_LOOKUP, 32'h1234_5680, 32'h5555_5555, AlgoLra, 16'h5555);
    send(ACT_LOOKUP, 32'h0000_00fe, 32'haaaa_aaaa, AlgoOther, 16'haaaa);
    send(ACT_LOOKUP, 32'h7fff_ff00, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ActUnused, 32'hffff_ffff, 32'hffff_ffff, AlgoOther, 16'hffff);
    send(ACT_LOOKUP, 32'hffff_ffff, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff, AlgoOther, 16'hffff);
    send(ACT_LOOKUP, 32'hffff_ffff, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_INSERT, 32'h0102_0304, 32'hffff_ffff, AlgoFixed, 16'h0007);
    send(ACT_LOOKUP, 32'h0102_0304, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_LOOKUP, 32'h0102_0305, 32'h0000_0000, AlgoLfp, 16'h0000);
    send(ACT_LOOKUP, 32'h1102_0304, 32'h0000_0000, AlgoLfp, 16'h0000);
    drain();

    // storage exhausted, with a long result hold-off on the way
    hold_request = 1'b1;
    subnet_phase($urandom_range(262, 275), 1'b1);
    drain();

    phase = 0;
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 9) == 0)
        subnet_phase($urandom_range(258, 270), 1'b1);
      else
        subnet_phase($urandom_range(30, 120), 1'b0);
      if ($urandom_range(0, 3) == 0 || phase == 1) drain();
      if (phase == 2) hold_request = 1'b1;
      phase++;
    end

    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
